### src/pnws_pkg.sv
package pnws_pkg;

    // Command codes of an input beat
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_MSG    = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;

    // Status values
    localparam logic [7:0] STS_STOP = 8'd0;
    localparam logic [7:0] STS_RUN  = 8'd1;

    // Cause codes of a result beat
    localparam logic [1:0] CAUSE_MSG     = 2'd0;
    localparam logic [1:0] CAUSE_RESEND  = 2'd1;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;
    localparam logic [1:0] CAUSE_STOP    = 2'd3;

    // Counter idle marks and reset values
    localparam logic [15:0] SIL_IDLE   = 16'hFFFF;
    localparam logic [7:0]  RES_IDLE   = 8'hFF;
    localparam logic [7:0]  ALIVE_INIT = 8'hFF;

    // Request bit positions inside the message bytes
    localparam int BIT_PNC16 = 7;
    localparam int BIT_PNC40 = 7;
    localparam int BIT_PNC43 = 4;
    localparam int BIT_PNC44 = 3;

    // Configuration register map
    localparam int          CFG_AW          = 1;
    localparam int          CFG_DW          = 16;
    localparam logic [0:0]  CFG_TIMEOUT     = 1'd0;
    localparam logic [0:0]  CFG_RESEND      = 1'd1;
    localparam logic [15:0] TIMEOUT_DEFAULT = 16'd3000;
    localparam logic [7:0]  RESEND_DEFAULT  = 8'd100;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] status_value;
        logic [7:0] alive_count;
        logic [7:0] byte_pnc_16_23;
        logic [7:0] byte_pnc_40_47;
    } t_in_item;

    typedef struct packed {
        logic       wake_pnc16;
        logic       wake_pnc40;
        logic       wake_pnc43;
        logic       wake_pnc44;
        logic [1:0] cause;
    } t_out_item;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  resend_ticks;
    } t_cfg;

endpackage

### src/pnws_in_if.sv
interface pnws_in_if import pnws_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/pnws_out_if.sv
interface pnws_out_if import pnws_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/pnws_core.sv
module pnws_core import pnws_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_emit,
    output t_out_item o_result
);

    logic        r_running, n_running;
    logic [15:0] r_sil, n_sil;
    logic [7:0]  r_res, n_res;
    logic [7:0]  r_alive, n_alive;
    logic [3:0]  r_req, n_req;

    logic [15:0] w_sil_mid;
    logic [7:0]  w_res_mid;
    logic        w_tmo_fire;
    logic        w_res_fire;
    logic        w_msg_ok;
    logic [3:0]  w_msg_req;

    // Decode the request bits of a message
    assign w_msg_req = {i_item.byte_pnc_40_47[BIT_PNC44], i_item.byte_pnc_40_47[BIT_PNC43],
                        i_item.byte_pnc_40_47[BIT_PNC40], i_item.byte_pnc_16_23[BIT_PNC16]};
    assign w_msg_ok  = r_running && (i_item.alive_count != r_alive);

    // Timeout check first; it idles the resend counter so both never fire
    assign w_tmo_fire = (r_sil >= i_cfg.timeout_ticks) && (r_sil != SIL_IDLE);
    assign w_sil_mid  = w_tmo_fire ? SIL_IDLE : r_sil;
    assign w_res_mid  = w_tmo_fire ? RES_IDLE : r_res;
    assign w_res_fire = (w_res_mid >= i_cfg.resend_ticks) && (w_res_mid != RES_IDLE);

    // Compute next state and the result of the current beat
    always_comb begin
        n_running = r_running;
        n_sil     = r_sil;
        n_res     = r_res;
        n_alive   = r_alive;
        n_req     = r_req;
        o_emit    = 1'b0;
        o_result  = '{wake_pnc16: 1'b0, wake_pnc40: 1'b0, wake_pnc43: 1'b0,
                      wake_pnc44: 1'b0, cause: CAUSE_MSG};
        unique case (i_item.cmd)
            CMD_TICK: begin
                if (r_running) begin
                    n_sil = w_sil_mid;
                    n_res = w_res_fire ? 8'd0 : w_res_mid;
                    if (w_tmo_fire) begin
                        o_emit         = 1'b1;
                        o_result.cause = CAUSE_TIMEOUT;
                    end
                    if (w_res_fire) begin
                        o_emit              = 1'b1;
                        o_result.wake_pnc16 = r_req[0];
                        o_result.wake_pnc40 = r_req[1];
                        o_result.wake_pnc43 = r_req[2];
                        o_result.wake_pnc44 = r_req[3];
                        o_result.cause      = CAUSE_RESEND;
                    end
                    if (n_sil != SIL_IDLE) begin
                        n_sil = n_sil + 16'd1;
                    end
                    if (n_res != RES_IDLE) begin
                        n_res = n_res + 8'd1;
                    end
                end
            end
            CMD_MSG: begin
                if (w_msg_ok) begin
                    n_alive             = i_item.alive_count;
                    n_sil               = '0;
                    n_res               = '0;
                    n_req               = w_msg_req;
                    o_emit              = 1'b1;
                    o_result.wake_pnc16 = w_msg_req[0];
                    o_result.wake_pnc40 = w_msg_req[1];
                    o_result.wake_pnc43 = w_msg_req[2];
                    o_result.wake_pnc44 = w_msg_req[3];
                    o_result.cause      = CAUSE_MSG;
                end
            end
            CMD_STATUS: begin
                if (i_item.status_value == STS_RUN) begin
                    if (!r_running) begin
                        n_sil   = '0;
                        n_alive = ALIVE_INIT;
                        n_req   = '0;
                    end
                    n_running = 1'b1;
                end else if (i_item.status_value == STS_STOP) begin
                    n_sil          = SIL_IDLE;
                    n_res          = RES_IDLE;
                    n_running      = 1'b0;
                    o_emit         = 1'b1;
                    o_result.cause = CAUSE_STOP;
                end
            end
            default: begin
            end
        endcase
    end

    // Advance state on a processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_sil     <= SIL_IDLE;
            r_res     <= RES_IDLE;
            r_alive   <= ALIVE_INIT;
            r_req     <= '0;
        end else if (i_go) begin
            r_running <= n_running;
            r_sil     <= n_sil;
            r_res     <= n_res;
            r_alive   <= n_alive;
            r_req     <= n_req;
        end
    end

    // Both counters rest at idle whenever the block is stopped
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_sil == SIL_IDLE) && (r_res == RES_IDLE))
        else $error("counters not idle while stopped");

    // A fresh message restarts both counters
    a_msg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && (i_item.cmd == CMD_MSG) && w_msg_ok |=> (r_sil == 16'd0) && (r_res == 8'd0))
        else $error("counters not cleared by message");

    // A stop always leaves the block stopped
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && (i_item.cmd == CMD_STATUS) && (i_item.status_value == STS_STOP)
        |=> !r_running)
        else $error("stop did not take effect");

    // Nothing but a stop is reported while stopped
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit && !r_running |-> o_result.cause == CAUSE_STOP)
        else $error("result while stopped");

endmodule

### src/partial_network_wake_supervisor.sv
// Result path: an accepted input beat is held in the input register, then its result
// beat, if it causes one, is loaded into the result register.
// Throughput: one input beat per cycle while input ready is high; a beat that causes no result still takes one slot.
// Input ready falls only while the result register holds an untaken beat and the input
// register is full.
// Reset (synchronous, active low): stopped, counters idle, registers at defaults.
module partial_network_wake_supervisor import pnws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pnws_in_if.sink           i_in,
    pnws_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    t_cfg      r_cfg;
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;

    logic      w_out_free;
    logic      w_go;
    logic      w_emit;
    t_out_item w_result;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= TIMEOUT_DEFAULT;
            r_cfg.resend_ticks  <= RESEND_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT: r_cfg.timeout_ticks <= i_cfg_wdata;
                CFG_RESEND:  r_cfg.resend_ticks  <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: process the held beat when the result slot is free
    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_go       = r_in_vld && w_out_free;
    assign i_in.ready = !r_in_vld || w_go;

    // Hold the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    pnws_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    // Load or drop the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_go) begin
            r_out_vld <= w_emit;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

### dv/partial_network_wake_supervisor_tb.sv
`timescale 1ns / 100ps

module partial_network_wake_supervisor_tb;
    import pnws_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 500000;

    // Expected wake beats, built from the accepted input beats
    class wake_request_board;
        t_out_item   wake_q[$];
        int          errors;
        int          beats_in;
        int          cause_seen[4];
        logic [15:0] timeout_ticks;
        logic [7:0]  resend_ticks;
        logic        running;
        logic [15:0] silence_cnt;
        logic [7:0]  resend_cnt;
        logic [7:0]  last_alive;
        logic [3:0]  stored_req;

        function new();
            errors        = 0;
            beats_in      = 0;
            cause_seen    = '{default: 0};
            timeout_ticks = TIMEOUT_DEFAULT;
            resend_ticks  = RESEND_DEFAULT;
            running       = 1'b0;
            silence_cnt   = SIL_IDLE;
            resend_cnt    = RES_IDLE;
            last_alive    = ALIVE_INIT;
            stored_req    = 4'b0;
        endfunction

        function void set_regs(logic [15:0] tmo, logic [7:0] rsd);
            timeout_ticks = tmo;
            resend_ticks  = rsd;
        endfunction

        function void queue_wake(logic [3:0] req, logic [1:0] cause);
            t_out_item w;
            w.wake_pnc16 = req[0];
            w.wake_pnc40 = req[1];
            w.wake_pnc43 = req[2];
            w.wake_pnc44 = req[3];
            w.cause      = cause;
            wake_q.push_back(w);
        endfunction

        // Advance the supervisor state by one accepted input beat
        function void predict_beat(t_in_item it);
            logic [3:0] req;
            beats_in++;
            case (it.cmd)
                CMD_TICK: begin
                    if (running) begin
                        if (silence_cnt >= timeout_ticks && silence_cnt != SIL_IDLE) begin
                            queue_wake(4'b0, CAUSE_TIMEOUT);
                            silence_cnt = SIL_IDLE;
                            resend_cnt  = RES_IDLE;
                        end
                        if (resend_cnt >= resend_ticks && resend_cnt != RES_IDLE) begin
                            queue_wake(stored_req, CAUSE_RESEND);
                            resend_cnt = 8'd0;
                        end
                        if (silence_cnt != SIL_IDLE) silence_cnt++;
                        if (resend_cnt != RES_IDLE) resend_cnt++;
                    end
                end
                CMD_MSG: begin
                    if (running && it.alive_count != last_alive) begin
                        last_alive  = it.alive_count;
                        silence_cnt = 16'd0;
                        resend_cnt  = 8'd0;
                        req[0] = it.byte_pnc_16_23[BIT_PNC16];
                        req[1] = it.byte_pnc_40_47[BIT_PNC40];
                        req[2] = it.byte_pnc_40_47[BIT_PNC43];
                        req[3] = it.byte_pnc_40_47[BIT_PNC44];
                        stored_req = req;
                        queue_wake(stored_req, CAUSE_MSG);
                    end
                end
                CMD_STATUS: begin
                    if (it.status_value == STS_RUN) begin
                        if (!running) begin
                            silence_cnt = 16'd0;
                            last_alive  = ALIVE_INIT;
                            stored_req  = 4'b0;
                        end
                        running = 1'b1;
                    end else if (it.status_value == STS_STOP) begin
                        silence_cnt = SIL_IDLE;
                        resend_cnt  = RES_IDLE;
                        queue_wake(4'b0, CAUSE_STOP);
                        running = 1'b0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [1:0] exp_v, logic [1:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one result beat with the oldest expectation
        function void check_wake_beat(t_out_item got);
            t_out_item exp_w;
            if (wake_q.size() == 0) begin
                $error("unexpected result beat: cause %0d, wake %b%b%b%b", got.cause,
                       got.wake_pnc16, got.wake_pnc40, got.wake_pnc43, got.wake_pnc44);
                errors++;
                return;
            end
            exp_w = wake_q.pop_front();
            cause_seen[exp_w.cause]++;
            check_field("wake_pnc16", 2'(exp_w.wake_pnc16), 2'(got.wake_pnc16));
            check_field("wake_pnc40", 2'(exp_w.wake_pnc40), 2'(got.wake_pnc40));
            check_field("wake_pnc43", 2'(exp_w.wake_pnc43), 2'(got.wake_pnc43));
            check_field("wake_pnc44", 2'(exp_w.wake_pnc44), 2'(got.wake_pnc44));
            check_field("cause", exp_w.cause, got.cause);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_wdata;

    pnws_in_if  in_if();
    pnws_out_if out_if();

    partial_network_wake_supervisor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    wake_request_board board = new();

    int         tx_idle_pct;
    int         rx_idle_pct;
    logic       hold_go;
    logic       gen_running;
    logic [7:0] next_alive;
    int         cycle_cnt;

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        out_if.ready = 1'b0;
        tx_idle_pct = 25;
        rx_idle_pct = 67;
        hold_go     = 1'b0;
        gen_running = 1'b0;
        next_alive  = 8'd0;
        cycle_cnt   = 0;
    end

    always #10 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Watch both channels
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) board.predict_beat(in_if.data);
        if (i_rst_n && out_if.valid && out_if.ready) board.check_wake_beat(out_if.data);
    end

    // Drive result ready: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic t_in_item mk(logic [1:0] cmd, logic [7:0] sts, logic [7:0] alive,
                                    logic [7:0] b16, logic [7:0] b40);
        return t_in_item'{cmd: cmd, status_value: sts, alive_count: alive,
                          byte_pnc_16_23: b16, byte_pnc_40_47: b40};
    endfunction

    // Offer one beat, with an optional random gap first, and hold it until accepted
    task automatic push_beat(input t_in_item it);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Drop valid and wait until every expected beat has come out
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.wake_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] tmo, input logic [7:0] rsd);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_TIMEOUT;
        i_cfg_wdata <= tmo;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_RESEND;
        i_cfg_wdata <= {8'($urandom), rsd};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_regs(tmo, rsd);
        @(posedge i_clk);
    endtask

    function automatic t_in_item fresh_msg();
        next_alive++;
        return mk(CMD_MSG, 8'($urandom), next_alive, 8'($urandom), 8'($urandom));
    endfunction

    // Mostly well-formed traffic: run, fresh messages, tick runs; some noise
    task automatic run_random(input int count, input int burst_max);
        t_in_item it;
        int       pick;
        int       sel;
        int       left;
        left = count;
        while (left > 0) begin
            it = mk(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            pick = $urandom_range(99);
            if (!gen_running && pick < 70) pick = 90;
            if (pick < 8) begin
                repeat ($urandom_range(burst_max, 1)) begin
                    it.status_value = 8'($urandom);
                    push_beat(it);
                    left--;
                end
            end else begin
                if (pick < 55) begin
                    it.cmd = CMD_TICK;
                end else if (pick < 85) begin
                    sel = $urandom_range(9);
                    if (sel < 7) begin
                        it = fresh_msg();
                    end else begin
                        it.cmd = CMD_MSG;
                        if (sel == 7) it.alive_count = next_alive;
                    end
                end else if (pick < 87) begin
                    it.cmd          = CMD_STATUS;
                    it.status_value = STS_STOP;
                    gen_running     = 1'b0;
                end else if (pick < 96) begin
                    it.cmd          = CMD_STATUS;
                    it.status_value = STS_RUN;
                    gen_running     = 1'b1;
                end else if (pick < 98) begin
                    it.cmd          = CMD_STATUS;
                    it.status_value = 8'($urandom_range(255, 2));
                end else begin
                    it.cmd = CMD_UNUSED;
                end
                push_beat(it);
                left--;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: stopped behavior, filtering and bit picks
        push_beat(mk(CMD_TICK,   8'h00,   8'h00, 8'hFF, 8'hFF));
        push_beat(mk(CMD_MSG,    8'hFF,   8'h00, 8'hFF, 8'hFF));
        push_beat(mk(CMD_STATUS, STS_STOP, 8'hFF, 8'hFF, 8'hFF));
        push_beat(mk(CMD_STATUS, 8'h02,   8'h00, 8'h00, 8'h00));
        push_beat(mk(CMD_STATUS, 8'hFF,   8'hFF, 8'hFF, 8'hFF));
        push_beat(mk(CMD_UNUSED, 8'hFF,   8'hFF, 8'hFF, 8'hFF));
        push_beat(mk(CMD_STATUS, STS_RUN, 8'h00, 8'h00, 8'h00));
        push_beat(mk(CMD_MSG,    8'h00,   8'hFF, 8'hFF, 8'hFF));
        push_beat(mk(CMD_MSG,    8'h00,   8'h00, 8'hFF, 8'hFF));
        push_beat(mk(CMD_MSG,    8'h00,   8'h00, 8'h00, 8'h00));
        push_beat(mk(CMD_MSG,    8'h00,   8'h01, 8'h7F, 8'h67));
        push_beat(mk(CMD_MSG,    8'h00,   8'h02, 8'h80, 8'h80));
        push_beat(mk(CMD_MSG,    8'h00,   8'h03, 8'h00, 8'h10));
        push_beat(mk(CMD_MSG,    8'h00,   8'h04, 8'h00, 8'h08));
        push_beat(mk(CMD_STATUS, STS_RUN, 8'h00, 8'h00, 8'h00));
        push_beat(mk(CMD_MSG,    8'h00,   8'h04, 8'hFF, 8'hFF));
        push_beat(mk(CMD_TICK,   8'hFF,   8'h00, 8'h00, 8'h00));
        push_beat(mk(CMD_STATUS, STS_STOP, 8'h00, 8'h00, 8'h00));
        push_beat(mk(CMD_STATUS, STS_RUN, 8'h00, 8'h00, 8'h00));
        push_beat(mk(CMD_MSG,    8'h00,   8'h04, 8'h80, 8'h18));
        push_beat(mk(CMD_MSG,    8'h00,   8'hFF, 8'h80, 8'h98));
        gen_running = 1'b1;
        next_alive  = 8'h10;
        run_random(240, 130);
        settle();

        // Tight thresholds: walk into a resend and a timeout by hand
        program_regs(16'd2, 8'd1);
        push_beat(mk(CMD_STATUS, STS_STOP, 8'h00, 8'h00, 8'h00));
        push_beat(mk(CMD_STATUS, STS_RUN, 8'h00, 8'h00, 8'h00));
        repeat (3) push_beat(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
        push_beat(mk(CMD_MSG, 8'h00, 8'h10, 8'h80, 8'h90));
        repeat (4) push_beat(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
        gen_running = 1'b1;
        run_random(240, 6);
        settle();

        tx_idle_pct = 67;
        rx_idle_pct = 25;
        program_regs(16'd1, 8'd254);
        run_random(240, 6);
        settle();

        program_regs(16'd65534, 8'd1);
        run_random(240, 8);
        settle();

        // Edge thresholds: all-ones never fires; a zero timeout fires on every tick while not idle
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(16'd0, 8'd0);
        run_random(200, 4);
        settle();

        program_regs(16'hFFFF, 8'hFF);
        run_random(200, 30);
        settle();

        // Hold result ready low while messages keep coming
        program_regs(16'($urandom_range(40, 5)), 8'($urandom_range(10, 2)));
        push_beat(mk(CMD_STATUS, STS_RUN, 8'($urandom), 8'($urandom), 8'($urandom)));
        gen_running = 1'b1;
        hold_go     = 1'b1;
        repeat (40) push_beat(fresh_msg());
        run_random(180, 60);
        settle();

        $display("Covered %0d input beats over seven register settings, incl. zero/all-ones.",
                 board.beats_in);
        $display("Result beats by cause: message %0d, resend %0d, timeout %0d, stop %0d",
                 board.cause_seen[CAUSE_MSG], board.cause_seen[CAUSE_RESEND],
                 board.cause_seen[CAUSE_TIMEOUT], board.cause_seen[CAUSE_STOP]);
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
